// File: sv/hpack_header_block_parser_defines.svh
// Assertion macros used by the header block parser RTL.
// Needs a clock named clk and an active high reset named rst in scope.
`ifndef HPACK_HEADER_BLOCK_PARSER_DEFINES_SVH
`define HPACK_HEADER_BLOCK_PARSER_DEFINES_SVH

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define HPK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the cycle after.
`define HPK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/hpk_pkg.sv
// Shared types and constants of the header block parser.
// Used by hpk_int_step, hpk_parse_core and hpack_header_block_parser.
package hpk_pkg;

  localparam int VALUE_BITS_DEFAULT = 32;
  localparam int OUT_VALUE_W = 32;

  // Continuation shift amount, saturating at 64.
  localparam int SHIFT_W = 7;
  localparam logic [SHIFT_W-1:0] SHIFT_SAT = 7'd64;
  localparam logic [SHIFT_W-1:0] GROUP_BITS = 7'd7;

  // Event kinds.
  localparam logic [2:0] EV_FIELD_INDEX = 3'd0;
  localparam logic [2:0] EV_NAME_INDEX  = 3'd1;
  localparam logic [2:0] EV_NAME_LEN    = 3'd2;
  localparam logic [2:0] EV_VALUE_LEN   = 3'd3;
  localparam logic [2:0] EV_NAME_BYTE   = 3'd4;
  localparam logic [2:0] EV_VALUE_BYTE  = 3'd5;
  localparam logic [2:0] EV_SIZE_UPDATE = 3'd6;
  localparam logic [2:0] EV_NONE        = 3'd7;

  // Field representations.
  localparam logic [2:0] REP_INDEXED     = 3'd0;
  localparam logic [2:0] REP_INCREMENTAL = 3'd1;
  localparam logic [2:0] REP_WITHOUT     = 3'd2;
  localparam logic [2:0] REP_NEVER       = 3'd3;
  localparam logic [2:0] REP_SIZE_UPDATE = 3'd4;

  // Error codes.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_TRUNC    = 2'd1;
  localparam logic [1:0] ERR_BAD_CODE = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // First byte of a field.
  localparam logic [7:0] HDR_BAD_INDEX   = 8'h80;
  localparam logic [7:0] HDR_INDEXED_MIN = 8'h81;
  localparam logic [7:0] HDR_INCR_MIN    = 8'h40;
  localparam logic [7:0] HDR_SIZE_MIN    = 8'h20;
  localparam logic [7:0] HDR_NEVER_MIN   = 8'h10;
  localparam logic [7:0] HDR_WITHOUT_LIT = 8'h00;

  // Integer prefix masks.
  localparam logic [6:0] PREFIX7 = 7'h7f;
  localparam logic [6:0] PREFIX6 = 7'h3f;
  localparam logic [6:0] PREFIX5 = 7'h1f;
  localparam logic [6:0] PREFIX4 = 7'h0f;

  typedef struct packed {
    logic overflow;
    logic done;
  } int_status_t;

  typedef struct packed {
    logic [2:0]             event_kind;
    logic [2:0]             representation;
    logic [OUT_VALUE_W-1:0] value;
    logic                   huffman;
    logic [1:0]             error_code;
    logic                   block_end;
  } result_t;

endpackage

// File: sv/hpack_header_block_parser.sv
// HPACK header block parser: takes one header block byte per request and
// reports field indexes, string lengths, string bytes and size updates. The
// block sustains one byte per clock cycle unless the output stalls: a byte goes
// from the input register through the field decode and one prefixed integer step
// into the result register, and all parsing state is updated in that same cycle.
// A byte that only continues an integer or opens a literal gives no result
// unless it raises an error or closes the block; the closing byte always gives
// one result with tlast set, except in a block already abandoned after an error.
// Depends on hpk_pkg, hpk_parse_core, hpk_int_step and the defines header.
`include "hpack_header_block_parser_defines.svh"

module hpack_header_block_parser #(
  parameter int VALUE_BITS = hpk_pkg::VALUE_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // block_last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] value
  output logic [8:0]  m_tuser,   // [2:0] event_kind, [5:3] representation,
                                 // [6] huffman, [8:7] error_code
  output logic        m_tlast    // block_end
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             in_last;
  logic             advance;
  logic             fire;
  logic             res_valid;
  hpk_pkg::result_t res;
  hpk_pkg::result_t out_res;

  // The result register can take a new result when empty or being emptied.
  assign advance  = !m_tvalid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  hpk_parse_core #(.VALUE_BITS(VALUE_BITS)) u_core (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .data_byte  (in_byte),
    .block_last (in_last),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= res;
    end
  end

  assign m_tdata = out_res.value;
  assign m_tuser = {out_res.error_code, out_res.huffman, out_res.representation,
                    out_res.event_kind};
  assign m_tlast = out_res.block_end;

  `HPK_ASSERT_IMPL(a_err_no_event, m_tvalid && (m_tuser[8:7] != hpk_pkg::ERR_NONE), (m_tuser[2:0] == hpk_pkg::EV_NONE) && (m_tdata == 32'd0), "error result carries an event")
  `HPK_ASSERT_IMPL(a_huff_len_only, m_tvalid && m_tuser[6], (m_tuser[2:0] == hpk_pkg::EV_NAME_LEN) || (m_tuser[2:0] == hpk_pkg::EV_VALUE_LEN), "huffman flag outside a length event")
  `HPK_ASSERT_IMPL(a_trunc_at_end, m_tvalid && (m_tuser[8:7] == hpk_pkg::ERR_TRUNC), m_tlast, "truncation reported before block end")
  `HPK_ASSERT_NEXT(a_held_result, m_tvalid && !m_tready && s_tvalid && s_tready, m_tvalid && in_valid, "request lost while result stalled")

endmodule

// File: sv/hpk_int_step.sv
// One continuation byte of a prefixed integer: accumulate, shift and overflow check.
// Depends on hpk_pkg.
module hpk_int_step #(
  parameter int VALUE_BITS = hpk_pkg::VALUE_BITS_DEFAULT
) (
  input  logic [VALUE_BITS-1:0]      accum,
  input  logic [hpk_pkg::SHIFT_W-1:0] shift,
  input  logic [7:0]                 data_byte,
  output logic [VALUE_BITS-1:0]      accum_next,
  output logic [hpk_pkg::SHIFT_W-1:0] shift_next,
  output hpk_pkg::int_status_t       status
);

  localparam int EW = VALUE_BITS + 7;

  logic [6:0]                  piece;
  logic [EW-1:0]               shifted;
  logic [EW-1:0]               sum;
  logic [hpk_pkg::SHIFT_W-1:0] sh7;

  assign piece   = data_byte[6:0];
  assign shifted = EW'(piece) << shift;
  assign sum     = EW'(accum) + shifted;
  assign sh7     = shift + hpk_pkg::GROUP_BITS;

  // The group fits only when the sum stays below 2^VALUE_BITS.
  assign status.overflow = (piece != 7'd0) &&
                           ((shift >= hpk_pkg::SHIFT_W'(VALUE_BITS)) ||
                            (sum[EW-1:VALUE_BITS] != 7'd0));
  assign status.done     = ~data_byte[7];
  assign accum_next      = sum[VALUE_BITS-1:0];
  assign shift_next      = (sh7 > hpk_pkg::SHIFT_SAT) ? hpk_pkg::SHIFT_SAT : sh7;

endmodule

// File: sv/hpk_parse_core.sv
// Field parser state and per-byte decode of the header block parser.
// Depends on hpk_pkg and hpk_int_step.
module hpk_parse_core #(
  parameter int VALUE_BITS = hpk_pkg::VALUE_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [7:0]       data_byte,
  input  logic             block_last,
  output logic             res_valid,
  output hpk_pkg::result_t res
);

  typedef enum logic [3:0] {
    PH_START, PH_IDX_CONT, PH_NLEN_FIRST, PH_NLEN_RAW, PH_NLEN_HUFF,
    PH_NAME_BYTES, PH_VLEN_FIRST, PH_VLEN_RAW, PH_VLEN_HUFF, PH_VAL_BYTES
  } phase_t;

  phase_t                      phase, phase_next;
  logic [2:0]                  field_kind, field_kind_next;
  logic [VALUE_BITS-1:0]       accum, accum_next;
  logic [hpk_pkg::SHIFT_W-1:0] shift, shift_next;
  logic [VALUE_BITS-1:0]       remaining, remaining_next;
  logic                        drop, drop_next;

  logic [VALUE_BITS-1:0]       int_accum;
  logic [hpk_pkg::SHIFT_W-1:0] int_shift;
  hpk_pkg::int_status_t        int_st;

  logic [2:0]                  ev_kind;
  logic [VALUE_BITS-1:0]       ev_val;
  logic                        ev_huff;
  logic [1:0]                  err;
  logic                        fin_idx, fin_len, len_isv, len_h;
  logic [VALUE_BITS-1:0]       idx_v, len_v, rem_dec;
  logic [6:0]                  mask;
  logic                        literal;
  logic [VALUE_BITS+31:0]      val_ext;

  hpk_int_step #(.VALUE_BITS(VALUE_BITS)) u_int_step (
    .accum      (accum),
    .shift      (shift),
    .data_byte  (data_byte),
    .accum_next (int_accum),
    .shift_next (int_shift),
    .status     (int_st)
  );

  assign rem_dec = (remaining != '0) ? remaining - VALUE_BITS'(1) : remaining;

  always_comb begin
    phase_next      = phase;
    field_kind_next = field_kind;
    accum_next      = accum;
    shift_next      = shift;
    remaining_next  = remaining;
    drop_next       = drop;
    ev_kind         = hpk_pkg::EV_NONE;
    ev_val          = '0;
    ev_huff         = 1'b0;
    err             = hpk_pkg::ERR_NONE;
    fin_idx         = 1'b0;
    fin_len         = 1'b0;
    idx_v           = '0;
    len_v           = '0;
    len_isv         = 1'b0;
    len_h           = 1'b0;
    mask            = hpk_pkg::PREFIX4;
    literal         = 1'b0;

    unique case (phase)
      PH_START: begin
        if (data_byte == hpk_pkg::HDR_BAD_INDEX) begin
          field_kind_next = hpk_pkg::REP_INDEXED;
          err             = hpk_pkg::ERR_BAD_CODE;
        end else begin
          if (data_byte >= hpk_pkg::HDR_INDEXED_MIN) begin
            field_kind_next = hpk_pkg::REP_INDEXED;
            mask            = hpk_pkg::PREFIX7;
          end else if (data_byte >= hpk_pkg::HDR_INCR_MIN) begin
            field_kind_next = hpk_pkg::REP_INCREMENTAL;
            mask            = hpk_pkg::PREFIX6;
            literal         = (data_byte == hpk_pkg::HDR_INCR_MIN);
          end else if (data_byte >= hpk_pkg::HDR_SIZE_MIN) begin
            field_kind_next = hpk_pkg::REP_SIZE_UPDATE;
            mask            = hpk_pkg::PREFIX5;
          end else if (data_byte >= hpk_pkg::HDR_NEVER_MIN) begin
            field_kind_next = hpk_pkg::REP_NEVER;
            mask            = hpk_pkg::PREFIX4;
            literal         = (data_byte == hpk_pkg::HDR_NEVER_MIN);
          end else begin
            field_kind_next = hpk_pkg::REP_WITHOUT;
            mask            = hpk_pkg::PREFIX4;
            literal         = (data_byte == hpk_pkg::HDR_WITHOUT_LIT);
          end
          if (literal) begin
            phase_next = PH_NLEN_FIRST;
          end else if ((data_byte[6:0] & mask) < mask) begin
            fin_idx = 1'b1;
            idx_v   = VALUE_BITS'(data_byte[6:0] & mask);
          end else begin
            accum_next = VALUE_BITS'(mask);
            shift_next = '0;
            phase_next = PH_IDX_CONT;
          end
        end
      end
      PH_IDX_CONT: begin
        if (int_st.overflow) begin
          err = hpk_pkg::ERR_OVERFLOW;
        end else begin
          accum_next = int_accum;
          shift_next = int_shift;
          fin_idx    = int_st.done;
          idx_v      = int_accum;
        end
      end
      PH_NLEN_FIRST, PH_VLEN_FIRST: begin
        if (data_byte[6:0] < hpk_pkg::PREFIX7) begin
          fin_len = 1'b1;
          len_v   = VALUE_BITS'(data_byte[6:0]);
          len_h   = data_byte[7];
          len_isv = (phase == PH_VLEN_FIRST);
        end else begin
          accum_next = VALUE_BITS'(data_byte[6:0]);
          shift_next = '0;
          if (phase == PH_VLEN_FIRST) begin
            phase_next = data_byte[7] ? PH_VLEN_HUFF : PH_VLEN_RAW;
          end else begin
            phase_next = data_byte[7] ? PH_NLEN_HUFF : PH_NLEN_RAW;
          end
        end
      end
      PH_NLEN_RAW, PH_NLEN_HUFF, PH_VLEN_RAW, PH_VLEN_HUFF: begin
        if (int_st.overflow) begin
          err = hpk_pkg::ERR_OVERFLOW;
        end else begin
          accum_next = int_accum;
          shift_next = int_shift;
          fin_len    = int_st.done;
          len_v      = int_accum;
          len_h      = (phase == PH_NLEN_HUFF) || (phase == PH_VLEN_HUFF);
          len_isv    = (phase == PH_VLEN_RAW) || (phase == PH_VLEN_HUFF);
        end
      end
      PH_NAME_BYTES, PH_VAL_BYTES: begin
        ev_kind        = (phase == PH_VAL_BYTES) ? hpk_pkg::EV_VALUE_BYTE
                                                 : hpk_pkg::EV_NAME_BYTE;
        ev_val         = VALUE_BITS'(data_byte);
        remaining_next = rem_dec;
        if (rem_dec == '0) begin
          phase_next = (phase == PH_VAL_BYTES) ? PH_START : PH_VLEN_FIRST;
        end
      end
      default: begin
        phase_next = PH_START;
      end
    endcase

    if (fin_idx) begin
      ev_val = idx_v;
      if (field_kind_next == hpk_pkg::REP_INDEXED) begin
        ev_kind    = hpk_pkg::EV_FIELD_INDEX;
        phase_next = PH_START;
      end else if (field_kind_next == hpk_pkg::REP_SIZE_UPDATE) begin
        ev_kind    = hpk_pkg::EV_SIZE_UPDATE;
        phase_next = PH_START;
      end else begin
        ev_kind    = hpk_pkg::EV_NAME_INDEX;
        phase_next = PH_VLEN_FIRST;
      end
    end

    if (fin_len) begin
      ev_kind        = len_isv ? hpk_pkg::EV_VALUE_LEN : hpk_pkg::EV_NAME_LEN;
      ev_val         = len_v;
      ev_huff        = len_h;
      remaining_next = len_v;
      if (len_v != '0) begin
        phase_next = len_isv ? PH_VAL_BYTES : PH_NAME_BYTES;
      end else begin
        phase_next = len_isv ? PH_START : PH_VLEN_FIRST;
      end
    end

    // A field still open on the block's last byte turns into a truncation error.
    if (err != hpk_pkg::ERR_NONE) begin
      drop_next  = ~block_last;
      phase_next = PH_START;
    end else if (block_last && (phase_next != PH_START)) begin
      err        = hpk_pkg::ERR_TRUNC;
      phase_next = PH_START;
    end
    if (err != hpk_pkg::ERR_NONE) begin
      ev_kind = hpk_pkg::EV_NONE;
      ev_val  = '0;
      ev_huff = 1'b0;
    end
  end

  assign val_ext = {32'b0, ev_val};

  assign res_valid = fire && !drop &&
                     ((err != hpk_pkg::ERR_NONE) || (ev_kind != hpk_pkg::EV_NONE) ||
                      block_last);
  assign res.event_kind     = ev_kind;
  assign res.representation = field_kind_next;
  assign res.value          = val_ext[hpk_pkg::OUT_VALUE_W-1:0];
  assign res.huffman        = ev_huff;
  assign res.error_code     = err;
  assign res.block_end      = block_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_START;
      field_kind <= hpk_pkg::REP_INDEXED;
      accum      <= '0;
      shift      <= '0;
      remaining  <= '0;
      drop       <= 1'b0;
    end else if (fire) begin
      if (drop) begin
        // Bytes of a failed block are discarded up to its last byte.
        if (block_last) begin
          drop  <= 1'b0;
          phase <= PH_START;
        end
      end else begin
        phase      <= phase_next;
        field_kind <= field_kind_next;
        accum      <= accum_next;
        shift      <= shift_next;
        remaining  <= remaining_next;
        drop       <= drop_next;
      end
    end
  end

endmodule

// File: tb/sv/tb_hpack_header_block_parser.sv
// Self-checking testbench for the HPACK header block parser: directed header
// blocks, then random well-formed and broken blocks checked against a predictor.
// Depends on hpk_pkg and the hpack_header_block_parser RTL.
`timescale 1ns / 100ps

module tb_hpack_header_block_parser;

  typedef enum logic [3:0] {
    PH_FIELD_START,
    PH_INDEX_MORE,
    PH_NAME_LEN_FIRST,
    PH_NAME_LEN_RAW,
    PH_NAME_LEN_HUFF,
    PH_NAME_DATA,
    PH_VALUE_LEN_FIRST,
    PH_VALUE_LEN_RAW,
    PH_VALUE_LEN_HUFF,
    PH_VALUE_DATA
  } parse_phase_e;

  localparam int GROUP_MORE = 0;
  localparam int GROUP_DONE = 1;
  localparam int GROUP_OVERFLOW = 2;
  localparam logic [63:0] VALUE_MAX = (64'd1 << hpk_pkg::VALUE_BITS_DEFAULT) - 64'd1;
  localparam logic [7:0] INDEXED_FLAG = 8'h80;
  localparam logic [7:0] HUFF_FLAG = 8'h80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [31:0] m_tdata;
  logic [8:0]  m_tuser;
  logic        m_tlast;

  // Predictor state.
  parse_phase_e ph = PH_FIELD_START;
  logic [2:0]   rep_cur = hpk_pkg::REP_INDEXED;
  logic [63:0]  acc = '0;
  int           shift_amt = 0;
  logic [63:0]  str_left = '0;
  bit           skip_block = 1'b0;
  logic [2:0]   ev_kind;
  logic [63:0]  ev_val;
  logic         ev_huff;

  hpk_pkg::result_t pending_events[$];
  logic [7:0]  block_q[$];
  int          parsed_bytes = 0;
  int          mismatches = 0;
  int          max_gap = 0;
  int          burst_left = 0;
  bit          stalls_on = 1'b0;
  logic [15:0] rx_pattern = 16'hffff;
  logic [3:0]  rx_pos = 4'd0;

  hpack_header_block_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver stalls follow a rotating 16-bit pattern that is reloaded after each
  // pass through its bits, sometimes sparse and sometimes dense.
  always @(posedge clk) begin
    if (rst || !stalls_on) m_tready <= 1'b1;
    else m_tready <= rx_pattern[rx_pos];
    rx_pos <= rx_pos + 4'd1;
    if (rx_pos == 4'hf) begin
      rx_pattern <= ($urandom_range(0, 3) == 0) ? 16'($urandom) & 16'($urandom)
                                               : 16'($urandom) | 16'($urandom);
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 200) begin
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    end
  endtask

  // One 7-bit continuation group of a prefixed integer.
  function automatic int add_group(logic [7:0] b);
    logic [63:0] piece;
    piece = {57'd0, b[6:0]};
    if (piece != 64'd0) begin
      if (shift_amt >= 64) return GROUP_OVERFLOW;
      if (piece > ((VALUE_MAX - acc) >> shift_amt)) return GROUP_OVERFLOW;
      acc = acc + (piece << shift_amt);
    end
    shift_amt = (shift_amt + 7 > 64) ? 64 : shift_amt + 7;
    return b[7] ? GROUP_MORE : GROUP_DONE;
  endfunction

  function automatic void close_index(logic [63:0] v);
    ev_val = v;
    if (rep_cur == hpk_pkg::REP_INDEXED) begin
      ev_kind = hpk_pkg::EV_FIELD_INDEX;
      ph = PH_FIELD_START;
    end else if (rep_cur == hpk_pkg::REP_SIZE_UPDATE) begin
      ev_kind = hpk_pkg::EV_SIZE_UPDATE;
      ph = PH_FIELD_START;
    end else begin
      ev_kind = hpk_pkg::EV_NAME_INDEX;
      ph = PH_VALUE_LEN_FIRST;
    end
  endfunction

  function automatic void close_length(bit is_val, logic h, logic [63:0] v);
    ev_kind = is_val ? hpk_pkg::EV_VALUE_LEN : hpk_pkg::EV_NAME_LEN;
    ev_val = v;
    ev_huff = h;
    str_left = v;
    if (v != 64'd0) ph = is_val ? PH_VALUE_DATA : PH_NAME_DATA;
    else ph = is_val ? PH_FIELD_START : PH_VALUE_LEN_FIRST;
  endfunction

  function automatic void open_length(bit is_val, logic [7:0] b);
    if (b[6:0] != hpk_pkg::PREFIX7) begin
      close_length(is_val, b[7], {57'd0, b[6:0]});
    end else begin
      acc = {57'd0, hpk_pkg::PREFIX7};
      shift_amt = 0;
      if (is_val) ph = b[7] ? PH_VALUE_LEN_HUFF : PH_VALUE_LEN_RAW;
      else ph = b[7] ? PH_NAME_LEN_HUFF : PH_NAME_LEN_RAW;
    end
  endfunction

  // Advances the parse state by one accepted byte and queues the event it causes.
  task automatic parse_byte(input logic [7:0] b, input bit last);
    logic [6:0]       mask;
    logic [1:0]       err;
    bit               lit;
    bit               is_val;
    logic             huff;
    int               grp;
    hpk_pkg::result_t ev;
    if (skip_block) begin
      if (last) begin
        skip_block = 1'b0;
        ph = PH_FIELD_START;
      end
      return;
    end
    parsed_bytes++;
    err = hpk_pkg::ERR_NONE;
    ev_kind = hpk_pkg::EV_NONE;
    ev_val = '0;
    ev_huff = 1'b0;
    case (ph)
      PH_FIELD_START: begin
        if (b == hpk_pkg::HDR_BAD_INDEX) begin
          rep_cur = hpk_pkg::REP_INDEXED;
          err = hpk_pkg::ERR_BAD_CODE;
        end else begin
          lit = 1'b0;
          if (b >= hpk_pkg::HDR_INDEXED_MIN) begin
            rep_cur = hpk_pkg::REP_INDEXED;
            mask = hpk_pkg::PREFIX7;
          end else if (b >= hpk_pkg::HDR_INCR_MIN) begin
            rep_cur = hpk_pkg::REP_INCREMENTAL;
            mask = hpk_pkg::PREFIX6;
            lit = (b == hpk_pkg::HDR_INCR_MIN);
          end else if (b >= hpk_pkg::HDR_SIZE_MIN) begin
            rep_cur = hpk_pkg::REP_SIZE_UPDATE;
            mask = hpk_pkg::PREFIX5;
          end else if (b >= hpk_pkg::HDR_NEVER_MIN) begin
            rep_cur = hpk_pkg::REP_NEVER;
            mask = hpk_pkg::PREFIX4;
            lit = (b == hpk_pkg::HDR_NEVER_MIN);
          end else begin
            rep_cur = hpk_pkg::REP_WITHOUT;
            mask = hpk_pkg::PREFIX4;
            lit = (b == hpk_pkg::HDR_WITHOUT_LIT);
          end
          if (lit) begin
            ph = PH_NAME_LEN_FIRST;
          end else if ((b[6:0] & mask) < mask) begin
            close_index({57'd0, b[6:0] & mask});
          end else begin
            acc = {57'd0, mask};
            shift_amt = 0;
            ph = PH_INDEX_MORE;
          end
        end
      end
      PH_INDEX_MORE: begin
        grp = add_group(b);
        if (grp == GROUP_OVERFLOW) err = hpk_pkg::ERR_OVERFLOW;
        else if (grp == GROUP_DONE) close_index(acc);
      end
      PH_NAME_LEN_FIRST: open_length(1'b0, b);
      PH_VALUE_LEN_FIRST: open_length(1'b1, b);
      PH_NAME_LEN_RAW, PH_NAME_LEN_HUFF, PH_VALUE_LEN_RAW, PH_VALUE_LEN_HUFF: begin
        is_val = (ph == PH_VALUE_LEN_RAW) || (ph == PH_VALUE_LEN_HUFF);
        huff = (ph == PH_NAME_LEN_HUFF) || (ph == PH_VALUE_LEN_HUFF);
        grp = add_group(b);
        if (grp == GROUP_OVERFLOW) err = hpk_pkg::ERR_OVERFLOW;
        else if (grp == GROUP_DONE) close_length(is_val, huff, acc);
      end
      default: begin
        is_val = (ph == PH_VALUE_DATA);
        ev_kind = is_val ? hpk_pkg::EV_VALUE_BYTE : hpk_pkg::EV_NAME_BYTE;
        ev_val = {56'd0, b};
        if (str_left != 64'd0) str_left = str_left - 64'd1;
        if (str_left == 64'd0) ph = is_val ? PH_FIELD_START : PH_VALUE_LEN_FIRST;
      end
    endcase

    if (err != hpk_pkg::ERR_NONE) begin
      skip_block = !last;
      ph = PH_FIELD_START;
    end else if (last && ph != PH_FIELD_START) begin
      err = hpk_pkg::ERR_TRUNC;
      ph = PH_FIELD_START;
    end
    if (err != hpk_pkg::ERR_NONE) begin
      ev_kind = hpk_pkg::EV_NONE;
      ev_val = '0;
      ev_huff = 1'b0;
    end else if (ev_kind == hpk_pkg::EV_NONE && !last) begin
      return;
    end
    ev.event_kind = ev_kind;
    ev.representation = rep_cur;
    ev.value = ev_val[31:0];
    ev.huffman = ev_huff;
    ev.error_code = err;
    ev.block_end = last;
    pending_events.push_back(ev);
  endtask

  always @(posedge clk) begin : check_events
    hpk_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("result with nothing pending", m_tdata, '0);
      end else begin
        want = pending_events.pop_front();
        if (m_tuser[2:0] !== want.event_kind)
          report_mismatch("event_kind", 32'(m_tuser[2:0]), 32'(want.event_kind));
        if (m_tuser[5:3] !== want.representation)
          report_mismatch("representation", 32'(m_tuser[5:3]), 32'(want.representation));
        if (m_tdata !== want.value)
          report_mismatch("value", m_tdata, want.value);
        if (m_tuser[6] !== want.huffman)
          report_mismatch("huffman", 32'(m_tuser[6]), 32'(want.huffman));
        if (m_tuser[8:7] !== want.error_code)
          report_mismatch("error_code", 32'(m_tuser[8:7]), 32'(want.error_code));
        if (m_tlast !== want.block_end)
          report_mismatch("block_end", 32'(m_tlast), 32'(want.block_end));
      end
    end
  end

  // Sends one byte request; the sender may idle between bursts of random length.
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    parse_byte(b, last);
  endtask

  task automatic send_block();
    foreach (block_q[i]) send_byte(block_q[i], i == block_q.size() - 1);
  endtask

  // Prefixed integer with the given flag bits; pad adds redundant zero groups.
  function automatic void push_int(logic [7:0] flags, int nbits, logic [63:0] v, int pad);
    logic [63:0] full;
    logic [63:0] rest;
    full = (64'd1 << nbits) - 64'd1;
    if (v < full) begin
      block_q.push_back(flags | v[7:0]);
      return;
    end
    block_q.push_back(flags | full[7:0]);
    rest = v - full;
    while (rest >= 64'd128) begin
      block_q.push_back({1'b1, rest[6:0]});
      rest = rest >> 7;
    end
    if (pad == 0) begin
      block_q.push_back({1'b0, rest[6:0]});
    end else begin
      block_q.push_back({1'b1, rest[6:0]});
      repeat (pad - 1) block_q.push_back(8'h80);
      block_q.push_back(8'h00);
    end
  endfunction

  function automatic int zero_pad();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(1, 10) : 0;
  endfunction

  function automatic logic [63:0] pick_int();
    case ($urandom_range(0, 39))
      0: return VALUE_MAX;
      1: return VALUE_MAX + 64'd1 + 64'($urandom_range(0, 1000));
      2, 3: return 64'($urandom);
      4, 5, 6, 7, 8, 9: return 64'($urandom_range(0, 300));
      default: return 64'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic [63:0] pick_length();
    case ($urandom_range(0, 29))
      0: return 64'd127;
      1: return 64'd126;
      2: return 64'($urandom_range(128, 200));
      3: return VALUE_MAX;
      4: return VALUE_MAX + 64'd1;
      default: return 64'($urandom_range(0, 6));
    endcase
  endfunction

  // Returns 1 when the string is too long to send, so the block ends inside it.
  function automatic bit push_string();
    logic [63:0] len;
    logic [7:0]  hflag;
    int          n;
    len = pick_length();
    hflag = $urandom_range(0, 1) ? HUFF_FLAG : 8'h00;
    push_int(hflag, 7, len, zero_pad());
    n = (len > 64'd300) ? 3 : int'(len);
    repeat (n) block_q.push_back(8'($urandom));
    return len > 64'd300;
  endfunction

  function automatic bit push_field();
    logic [63:0] idx;
    logic [7:0]  flags;
    int          nbits;
    bit          cut;
    cut = 1'b0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        idx = pick_int();
        push_int(INDEXED_FLAG, 7, (idx == 64'd0) ? 64'd1 : idx, zero_pad());
      end
      4: push_int(hpk_pkg::HDR_SIZE_MIN, 5, pick_int(), zero_pad());
      default: begin
        case ($urandom_range(0, 2))
          0: begin
            flags = hpk_pkg::HDR_INCR_MIN;
            nbits = 6;
          end
          1: begin
            flags = hpk_pkg::HDR_NEVER_MIN;
            nbits = 4;
          end
          default: begin
            flags = hpk_pkg::HDR_WITHOUT_LIT;
            nbits = 4;
          end
        endcase
        // A name index of zero means the name follows as a literal string.
        idx = $urandom_range(0, 1) ? 64'd0 : pick_int();
        push_int(flags, nbits, idx, zero_pad());
        if (idx == 64'd0) cut = push_string();
        if (!cut) cut = push_string();
      end
    endcase
    return cut;
  endfunction

  function automatic void build_block(bit broken);
    int nfields;
    int keep;
    bit cut;
    block_q.delete();
    cut = 1'b0;
    nfields = broken ? $urandom_range(0, 2) : $urandom_range(1, 4);
    for (int i = 0; i < nfields && !cut; i++) cut = push_field();
    if (broken && !cut) begin
      case ($urandom_range(0, 3))
        0: block_q.push_back(hpk_pkg::HDR_BAD_INDEX);
        1: repeat ($urandom_range(1, 6)) block_q.push_back(8'($urandom));
        2: begin
          // Zero groups saturate the shift, so the final nonzero group overflows.
          block_q.push_back(8'hFF);
          repeat (10) block_q.push_back(8'h80);
          block_q.push_back(8'h01);
        end
        default: push_int(hpk_pkg::HDR_SIZE_MIN, 5,
                          VALUE_MAX + 64'd1 + 64'($urandom_range(0, 1000)), 0);
      endcase
      repeat ($urandom_range(0, 4)) block_q.push_back(8'($urandom));
    end
    if (block_q.size() > 1 && $urandom_range(0, broken ? 2 : 9) == 0) begin
      keep = $urandom_range(1, block_q.size() - 1);
      while (block_q.size() > keep) void'(block_q.pop_back());
    end
  endfunction

  task automatic test_directed_cases();
    max_gap = 0;
    stalls_on = 1'b0;
    block_q = '{8'h82};
    send_block();
    // Indexed field whose integer overflows on the closing byte.
    block_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F};
    send_block();
    // Code 0x80 at the start of a block: the rest of the block is dropped silently.
    block_q = '{8'h80, 8'h81};
    send_block();
    block_q = '{8'h3F, 8'hE1, 8'h1F};
    send_block();
    block_q = '{8'h10, 8'h81, 8'hAA, 8'h00};
    send_block();
    block_q = '{8'h41, 8'h82, 8'h00, 8'hFF};
    send_block();
    // Blocks that end with a field still open.
    block_q = '{8'h0F, 8'h00};
    send_block();
    block_q = '{8'h00, 8'h7F};
    send_block();
  endtask

  task automatic test_wellformed_blocks();
    int goal;
    for (int mode = 0; mode < 4; mode++) begin
      max_gap = (mode == 1) ? 2 : (mode == 2) ? 8 : 0;
      stalls_on = (mode == 1) || (mode == 3);
      goal = parsed_bytes + 350;
      while (parsed_bytes < goal) begin
        build_block(1'b0);
        send_block();
      end
    end
  endtask

  task automatic test_broken_blocks();
    int goal;
    max_gap = 4;
    stalls_on = 1'b1;
    goal = parsed_bytes + 400;
    while (parsed_bytes < goal) begin
      build_block($urandom_range(0, 1));
      send_block();
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_wellformed_blocks();
    test_broken_blocks();
    s_tvalid <= 1'b0;
    wait_cycles = 0;
    while (pending_events.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    while (pending_events.size() != 0) begin
      report_mismatch("result never arrived", '0, pending_events[0].value);
      void'(pending_events.pop_front());
    end
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule
